// File: hdl/grid_local_extremum_finder_unit_assert.svh
// assertion macros shared by the rtl files
`ifndef GRID_LOCAL_EXTREMUM_FINDER_UNIT_ASSERT_SVH
`define GRID_LOCAL_EXTREMUM_FINDER_UNIT_ASSERT_SVH
`ifndef SYNTH
`define GLEF_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`define GLEF_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define GLEF_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define GLEF_NEVER(lbl, clk, rst_n, cond, msg)
`define GLEF_IMPLY(lbl, clk, rst_n, ante, cons, msg)
`define GLEF_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// File: hdl/glef_pkg.sv
package glef_pkg;

	localparam int ROW_W  = 6;
	localparam int COL_W  = 6;
	localparam int PEAK_W = 12;
	localparam logic [PEAK_W-1:0] PEAK_MAX = '1;

	localparam int CFG_W   = 7;
	localparam int PADDR_W = 3;

	// register index decoded from paddr[2]
	localparam logic REG_ROWS = 1'b0;
	localparam logic REG_COLS = 1'b1;

	localparam int FIFO_DEPTH = 16;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

	typedef enum logic [1:0] {
		KIND_PEAK    = 2'd0,
		KIND_VALLEY  = 2'd1,
		KIND_SUMMARY = 2'd2
	} kind_t;

	typedef struct packed {
		logic [FIFO_CW-1:0] count;
		logic               empty;
	} fifo_stat_t;

endpackage

// File: hdl/glef_result_fifo.sv
`include "grid_local_extremum_finder_unit_assert.svh"

module glef_result_fifo #(
	parameter int DATA_W = 43
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [1:0]          push_cnt,
	input  logic [DATA_W-1:0]   din0,
	input  logic [DATA_W-1:0]   din1,
	input  logic                pop,
	output logic [DATA_W-1:0]   dout,
	output glef_pkg::fifo_stat_t stat
);
	import glef_pkg::*;

	logic [DATA_W-1:0]  mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_ptr_q;
	logic [FIFO_AW-1:0] rd_ptr_q;
	logic [FIFO_CW-1:0] count_q;
	logic [FIFO_AW-1:0] wr_ptr_p1;

	assign wr_ptr_p1 = wr_ptr_q + FIFO_AW'(1);

	always_ff @(posedge clk) begin
		if (push_cnt != 2'd0) begin
			mem_q[wr_ptr_q] <= din0;
		end
		if (push_cnt == 2'd2) begin
			mem_q[wr_ptr_p1] <= din1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + FIFO_AW'(push_cnt);
			rd_ptr_q <= rd_ptr_q + FIFO_AW'(pop);
			count_q  <= count_q + FIFO_CW'(push_cnt) - FIFO_CW'(pop);
		end
	end

	assign dout       = mem_q[rd_ptr_q];
	assign stat.count = count_q;
	assign stat.empty = (count_q == '0);

	`GLEF_NEVER(a_fifo_bound, clk, arst_n, count_q > FIFO_CW'(FIFO_DEPTH), "fifo count over depth")
	`GLEF_NEVER(a_fifo_ovf, clk, arst_n, (count_q + FIFO_CW'(push_cnt)) > (FIFO_CW'(FIFO_DEPTH) + FIFO_CW'(pop)), "fifo overflow")
	`GLEF_IMPLY(a_fifo_udf, clk, arst_n, pop, count_q != '0, "pop from empty fifo")
	`GLEF_NEXT(a_fifo_inc, clk, arst_n, push_cnt == 2'd1 && !pop, count_q == $past(count_q) + 1'b1, "fifo count did not advance")

endmodule

// File: hdl/grid_local_extremum_finder_unit.sv
// an accepted sample passes the s1 registers, the 3x3 window and the s2 registers before
//   its results enter the output queue; result_valid rises combinationally with the queue count
// throughput: one sample per cycle unless sample_stall, one result per cycle unless result_stall
// sample_stall rises while the 16-entry result queue lacks two slots per new or in-flight sample
// reset: row, column and peak counters and the 3x3 window clear, grid size returns to 64 x 64
//   line stores are not cleared and need no clearing pass
`include "grid_local_extremum_finder_unit_assert.svh"

module grid_local_extremum_finder_unit #(
	parameter int MAX_DIM     = 64,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [glef_pkg::PADDR_W-1:0]         paddr,
	input  logic [31:0]                          pwdata,
	output logic [31:0]                          prdata,
	output logic                                 pready,
	input  logic                                 sample_valid,
	output logic                                 sample_stall,
	input  logic signed [SAMPLE_BITS-1:0]        elevation,
	output logic                                 result_valid,
	input  logic                                 result_stall,
	output glef_pkg::kind_t                      kind,
	output logic [glef_pkg::ROW_W-1:0]           row,
	output logic [glef_pkg::COL_W-1:0]           col,
	output logic signed [SAMPLE_BITS-1:0]        height,
	output logic [glef_pkg::PEAK_W-1:0]          peak_total,
	output logic                                 last
);
	import glef_pkg::*;

	localparam int CNT_W = $clog2(MAX_DIM);
	localparam int DIM_W = $clog2(MAX_DIM + 1);
	localparam int EXT_W = (DIM_W > CFG_W) ? DIM_W : CFG_W;
	localparam int SLOT  = 2;

	typedef struct packed {
		kind_t                        kind;
		logic [ROW_W-1:0]             row;
		logic [COL_W-1:0]             col;
		logic signed [SAMPLE_BITS-1:0] height;
		logic [PEAK_W-1:0]            peak_total;
		logic                         last;
	} result_t;

	// configuration
	logic [CFG_W-1:0] rows_q, cols_q;
	logic             cfg_wr;
	logic [DIM_W-1:0] rows_eff, cols_eff;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= CFG_W'(64);
			cols_q <= CFG_W'(64);
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_ROWS: rows_q <= pwdata[CFG_W-1:0];
				REG_COLS: cols_q <= pwdata[CFG_W-1:0];
				default:  ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_ROWS: prdata = 32'(rows_q);
			REG_COLS: prdata = 32'(cols_q);
			default:  prdata = '0;
		endcase
	end

	always_comb begin
		if (rows_q == '0) begin
			rows_eff = DIM_W'(1);
		end else if (EXT_W'(rows_q) > EXT_W'(MAX_DIM)) begin
			rows_eff = DIM_W'(MAX_DIM);
		end else begin
			rows_eff = DIM_W'(rows_q);
		end
		if (cols_q == '0) begin
			cols_eff = DIM_W'(1);
		end else if (EXT_W'(cols_q) > EXT_W'(MAX_DIM)) begin
			cols_eff = DIM_W'(MAX_DIM);
		end else begin
			cols_eff = DIM_W'(cols_q);
		end
	end

	// stage 0: accept, raster counters, line store read
	logic             in_fire;
	logic [CNT_W-1:0] row_q, col_q;
	logic             col_last, row_last;
	logic             s1_valid, s2_valid;
	fifo_stat_t       fifo_stat;
	logic [FIFO_CW-1:0] need;

	assign need = FIFO_CW'(SLOT) + (s1_valid ? FIFO_CW'(SLOT) : '0)
		+ (s2_valid ? FIFO_CW'(SLOT) : '0);
	assign sample_stall = ({1'b0, fifo_stat.count} + {1'b0, need}) > (FIFO_CW + 1)'(FIFO_DEPTH);
	assign in_fire  = sample_valid && !sample_stall;
	assign col_last = (DIM_W'(col_q) + DIM_W'(1)) >= cols_eff;
	assign row_last = (DIM_W'(row_q) + DIM_W'(1)) >= rows_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else if (cfg_wr) begin
			row_q <= '0;
			col_q <= '0;
		end else if (in_fire) begin
			if (col_last) begin
				col_q <= '0;
				row_q <= row_last ? '0 : row_q + CNT_W'(1);
			end else begin
				col_q <= col_q + CNT_W'(1);
			end
		end
	end

	logic signed [SAMPLE_BITS-1:0] upper_mem [MAX_DIM];
	logic signed [SAMPLE_BITS-1:0] middle_mem [MAX_DIM];
	logic signed [SAMPLE_BITS-1:0] upper_rd_s1, middle_rd_s1, key_s1;
	logic signed [SAMPLE_BITS-1:0] up_eff, mid_eff, wr_up_q, wr_mid_q;
	logic [CNT_W-1:0] r_s1, c_s1, r_s2, c_s2;
	logic             test_s1, end_s1, test_s2, end_s2, fwd_s1;

	always_ff @(posedge clk) begin
		if (in_fire) begin
			upper_rd_s1  <= upper_mem[col_q];
			middle_rd_s1 <= middle_mem[col_q];
			key_s1       <= elevation;
			r_s1         <= row_q;
			c_s1         <= col_q;
			test_s1      <= (row_q >= CNT_W'(2)) && (col_q >= CNT_W'(2));
			end_s1       <= col_last && row_last;
		end
		if (s1_valid) begin
			upper_mem[c_s1]  <= mid_eff;
			middle_mem[c_s1] <= key_s1;
			wr_up_q          <= mid_eff;
			wr_mid_q         <= key_s1;
			r_s2             <= r_s1;
			c_s2             <= c_s1;
			test_s2          <= test_s1;
			end_s2           <= end_s1;
		end
	end

	// the read misses a write to the same column landing at the same edge
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
			s2_valid <= 1'b0;
			fwd_s1   <= 1'b0;
		end else begin
			s1_valid <= in_fire && !cfg_wr;
			s2_valid <= s1_valid;
			if (in_fire) begin
				fwd_s1 <= s1_valid && (c_s1 == col_q);
			end
		end
	end

	assign up_eff  = fwd_s1 ? wr_up_q  : upper_rd_s1;
	assign mid_eff = fwd_s1 ? wr_mid_q : middle_rd_s1;

	// stage 1: window shift
	logic signed [SAMPLE_BITS-1:0] win_q [3][3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int a = 0; a < 3; a++) begin
				for (int b = 0; b < 3; b++) begin
					win_q[a][b] <= '0;
				end
			end
		end else if (s1_valid) begin
			for (int k = 0; k < 3; k++) begin
				win_q[k][0] <= win_q[k][1];
				win_q[k][1] <= win_q[k][2];
			end
			win_q[0][2] <= up_eff;
			win_q[1][2] <= mid_eff;
			win_q[2][2] <= key_s1;
		end
	end

	// stage 2: neighbour test and result push
	logic              gt, lt, det, summ;
	logic [PEAK_W-1:0] peak_q, peak_next;
	result_t           det_res, sum_res, push0, fifo_dout;
	logic [1:0]        push_cnt;
	logic              pop;

	always_comb begin
		gt = 1'b1;
		lt = 1'b1;
		for (int a = 0; a < 3; a++) begin
			for (int b = 0; b < 3; b++) begin
				if (!(a == 1 && b == 1)) begin
					if (!(win_q[1][1] > win_q[a][b])) gt = 1'b0;
					if (!(win_q[1][1] < win_q[a][b])) lt = 1'b0;
				end
			end
		end
	end

	assign det  = s2_valid && test_s2 && (gt || lt);
	assign summ = s2_valid && end_s2;
	assign peak_next = (det && gt && peak_q != PEAK_MAX) ? peak_q + PEAK_W'(1) : peak_q;

	always_comb begin
		det_res.kind       = gt ? KIND_PEAK : KIND_VALLEY;
		det_res.row        = ROW_W'(r_s2 - CNT_W'(1));
		det_res.col        = COL_W'(c_s2 - CNT_W'(1));
		det_res.height     = win_q[1][1];
		det_res.peak_total = peak_next;
		det_res.last       = !summ;
		sum_res.kind       = KIND_SUMMARY;
		sum_res.row        = '0;
		sum_res.col        = '0;
		sum_res.height     = '0;
		sum_res.peak_total = peak_next;
		sum_res.last       = 1'b1;
		push0              = det ? det_res : sum_res;
		push_cnt           = 2'(det) + 2'(summ);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			peak_q <= '0;
		end else if (cfg_wr) begin
			peak_q <= '0;
		end else if (s2_valid) begin
			peak_q <= summ ? '0 : peak_next;
		end
	end

	assign pop = result_valid && !result_stall;

	glef_result_fifo #(
		.DATA_W($bits(result_t))
	) u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push_cnt(push_cnt),
		.din0    (push0),
		.din1    (sum_res),
		.pop     (pop),
		.dout    (fifo_dout),
		.stat    (fifo_stat)
	);

	assign result_valid = !fifo_stat.empty;
	assign kind         = fifo_dout.kind;
	assign row          = fifo_dout.row;
	assign col          = fifo_dout.col;
	assign height       = fifo_dout.height;
	assign peak_total   = fifo_dout.peak_total;
	assign last         = fifo_dout.last;

	`GLEF_NEXT(a_peak_clear, clk, arst_n, summ, peak_q == '0, "peak count not cleared after summary")
	`GLEF_NEXT(a_peak_mono, clk, arst_n, s2_valid && !end_s2 && !cfg_wr, peak_q >= $past(peak_q), "peak count dropped inside a grid")
	`GLEF_NEXT(a_col_step, clk, arst_n, in_fire && !col_last && !cfg_wr, col_q == $past(col_q) + 1'b1, "column counter did not advance")

endmodule

// File: tb/grid_local_extremum_finder_unit_tb.sv
`timescale 1ns / 100ps

module grid_local_extremum_finder_unit_tb;
	import glef_pkg::*;

	localparam int STALL_LIMIT = 3000;
	localparam int HOLD_CYCLES = 300;
	localparam int RANDOM_ITEMS = 300;
	localparam int DIM_MAX = 64;

	localparam logic signed [15:0] PEAK_GRID [9] = '{
		-16'sd32768, 16'sd0, 16'sd32766,
		16'sd5, 16'sd32767, -16'sd1,
		16'sd32766, 16'sd32766, 16'sd100
	};
	localparam logic signed [15:0] VALLEY_GRID [9] = '{
		16'sd32767, -16'sd32767, 16'sd0,
		16'sd1, -16'sd32768, -16'sd32767,
		-16'sd1, 16'sd32767, 16'sd200
	};

	typedef enum int {PAT_WIDE, PAT_TIES, PAT_EXTREME, PAT_BUMPY} pattern_t;

	typedef struct {
		kind_t              kind;
		logic [ROW_W-1:0]   row;
		logic [COL_W-1:0]   col;
		logic signed [15:0] height;
		logic [PEAK_W-1:0]  peak_total;
		logic               last;
	} report_t;

	// predicts peak / valley / summary reports from the accepted sample stream
	class extremum_tracker;
		logic signed [15:0] upper_line [DIM_MAX];
		logic signed [15:0] middle_line [DIM_MAX];
		logic signed [15:0] win [3][3];
		int unsigned row_cnt;
		int unsigned col_cnt;
		logic [PEAK_W-1:0] peak_cnt;
		logic [CFG_W-1:0] rows_reg;
		logic [CFG_W-1:0] cols_reg;
		report_t awaited_reports[$];
		int error_count;

		function new();
			foreach (upper_line[i]) begin
				upper_line[i] = '0;
				middle_line[i] = '0;
			end
			foreach (win[a, b]) win[a][b] = '0;
			row_cnt = 0;
			col_cnt = 0;
			peak_cnt = '0;
			rows_reg = 7'd64;
			cols_reg = 7'd64;
			error_count = 0;
		endfunction

		function int unsigned eff_dim(logic [CFG_W-1:0] v);
			if (v == 0)
				return 1;
			if (v > DIM_MAX)
				return DIM_MAX;
			return v;
		endfunction

		function int awaited();
			return awaited_reports.size();
		endfunction

		// any register write restarts the grid
		function void set_dim(logic idx, logic [CFG_W-1:0] v);
			if (idx == REG_ROWS)
				rows_reg = v;
			else
				cols_reg = v;
			row_cnt = 0;
			col_cnt = 0;
			peak_cnt = '0;
		endfunction

		function void take_sample(logic signed [15:0] v);
			report_t fresh[$];
			report_t rep;
			int unsigned n_rows;
			int unsigned n_cols;
			int unsigned r;
			int unsigned c;
			logic signed [15:0] ctr;
			bit gt;
			bit lt;
			n_rows = eff_dim(rows_reg);
			n_cols = eff_dim(cols_reg);
			r = row_cnt;
			c = col_cnt;
			if (c >= n_cols)
				c = 0;
			if (r >= n_rows)
				r = 0;
			for (int k = 0; k < 3; k++) begin
				win[k][0] = win[k][1];
				win[k][1] = win[k][2];
			end
			win[0][2] = upper_line[c];
			win[1][2] = middle_line[c];
			win[2][2] = v;
			upper_line[c] = middle_line[c];
			middle_line[c] = v;

			if (r >= 2 && c >= 2) begin
				ctr = win[1][1];
				gt = 1'b1;
				lt = 1'b1;
				for (int a = 0; a < 3; a++) begin
					for (int b = 0; b < 3; b++) begin
						if (!(a == 1 && b == 1)) begin
							if (!(ctr > win[a][b]))
								gt = 1'b0;
							if (!(ctr < win[a][b]))
								lt = 1'b0;
						end
					end
				end
				if (gt) begin
					if (peak_cnt != PEAK_MAX)
						peak_cnt++;
					rep = '{kind: KIND_PEAK, row: ROW_W'(r - 1), col: COL_W'(c - 1),
						height: ctr, peak_total: peak_cnt, last: 1'b0};
					fresh.push_back(rep);
				end else if (lt) begin
					rep = '{kind: KIND_VALLEY, row: ROW_W'(r - 1), col: COL_W'(c - 1),
						height: ctr, peak_total: peak_cnt, last: 1'b0};
					fresh.push_back(rep);
				end
			end

			c++;
			if (c >= n_cols) begin
				c = 0;
				r++;
				if (r >= n_rows) begin
					rep = '{kind: KIND_SUMMARY, row: '0, col: '0, height: '0,
						peak_total: peak_cnt, last: 1'b0};
					fresh.push_back(rep);
					r = 0;
					peak_cnt = '0;
				end
			end
			row_cnt = r;
			col_cnt = c;

			if (fresh.size() > 0)
				fresh[fresh.size() - 1].last = 1'b1;
			foreach (fresh[i])
				awaited_reports.push_back(fresh[i]);
		endfunction

		function void check_report(kind_t kind, logic [ROW_W-1:0] row, logic [COL_W-1:0] col,
				logic signed [15:0] height, logic [PEAK_W-1:0] peak_total, logic last);
			report_t exp_rep;
			if (awaited_reports.size() == 0) begin
				$error("unexpected result: kind %0d row %0d col %0d height %0d",
					kind, row, col, height);
				error_count++;
				return;
			end
			exp_rep = awaited_reports.pop_front();
			if (kind !== exp_rep.kind) begin
				$error("kind: expected %0d, got %0d", exp_rep.kind, kind);
				error_count++;
			end
			if (row !== exp_rep.row) begin
				$error("row: expected %0d, got %0d", exp_rep.row, row);
				error_count++;
			end
			if (col !== exp_rep.col) begin
				$error("col: expected %0d, got %0d", exp_rep.col, col);
				error_count++;
			end
			if (height !== exp_rep.height) begin
				$error("height: expected %0d, got %0d", exp_rep.height, height);
				error_count++;
			end
			if (peak_total !== exp_rep.peak_total) begin
				$error("peak_total: expected %0d, got %0d", exp_rep.peak_total, peak_total);
				error_count++;
			end
			if (last !== exp_rep.last) begin
				$error("last: expected %0d, got %0d", exp_rep.last, last);
				error_count++;
			end
		endfunction
	endclass

	logic                      clk = 1'b0;
	logic                      arst_n;
	logic                      psel;
	logic                      penable;
	logic                      pwrite;
	logic [PADDR_W-1:0]        paddr;
	logic [31:0]               pwdata;
	logic [31:0]               prdata;
	logic                      pready;
	logic                      sample_valid;
	logic                      sample_stall;
	logic signed [15:0]        elevation;
	logic                      result_valid;
	logic                      result_stall;
	kind_t                     kind;
	logic [ROW_W-1:0]          row;
	logic [COL_W-1:0]          col;
	logic signed [15:0]        height;
	logic [PEAK_W-1:0]         peak_total;
	logic                      last;

	extremum_tracker tracker = new();

	bit no_idle;
	bit sender_burst;
	int hold_request;
	int hold_left;
	int run_left;
	bit run_stall;
	int idle_cycles;

	grid_local_extremum_finder_unit i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.elevation    (elevation),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.kind         (kind),
		.row          (row),
		.col          (col),
		.height       (height),
		.peak_total   (peak_total),
		.last         (last)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (sample_valid && !sample_stall)
				tracker.take_sample(elevation);
			if (result_valid && !result_stall)
				tracker.check_report(kind, row, col, height, peak_total, last);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (sample_valid && !sample_stall) || (result_valid && !result_stall)
				|| (psel && penable && pwrite && pready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// result side: random stall runs, or a long hold-off on request
	always @(negedge clk) begin
		if (hold_request != 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			result_stall <= 1'b1;
		end else if (no_idle) begin
			result_stall <= 1'b0;
		end else begin
			if (run_left == 0) begin
				case ($urandom_range(0, 99)) inside
					[0:54]: begin
						run_stall = 1'b0;
						run_left = $urandom_range(1, 12);
					end
					[55:92]: begin
						run_stall = 1'b1;
						run_left = $urandom_range(1, 3);
					end
					default: begin
						run_stall = 1'b1;
						run_left = $urandom_range(10, 40);
					end
				endcase
			end
			run_left--;
			result_stall <= run_stall;
		end
	end

	function automatic int pick_gap();
		int roll;
		if (no_idle || sender_burst)
			return 0;
		roll = $urandom_range(0, 99);
		if (roll < 65)
			return 0;
		if (roll < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic logic signed [15:0] make_elevation(pattern_t pat, int r, int c);
		case (pat)
			PAT_TIES:
				return 16'(int'($urandom_range(0, 4)) - 2);
			PAT_EXTREME:
				case ($urandom_range(0, 3))
					0: return -16'sd32768;
					1: return -16'sd32767;
					2: return 16'sd32766;
					default: return 16'sd32767;
				endcase
			PAT_BUMPY:
				if (r % 2 == 1 && c % 2 == 1)
					return 16'($urandom_range(1000, 32767));
				else
					return 16'(int'($urandom_range(0, 1999)) - 1000);
			default:
				return 16'($urandom);
		endcase
	endfunction

	task automatic send_sample(input logic signed [15:0] v);
		int gap;
		gap = pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			sample_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		sample_valid <= 1'b1;
		elevation <= v;
		do @(posedge clk); while (sample_stall);
	endtask

	task automatic send_grid(input int n, input int width, input pattern_t pat);
		for (int i = 0; i < n; i++)
			send_sample(make_elevation(pat, i / width, i % width));
	endtask

	// sender pauses until the output side has drained, then covers the pipeline latency
	task automatic wait_idle();
		@(negedge clk);
		sample_valid <= 1'b0;
		while (tracker.awaited() != 0) @(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic apb_write_reg(input logic idx, input logic [CFG_W-1:0] v);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= 32'(v);
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		tracker.set_dim(idx, v);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic configure(input logic [CFG_W-1:0] n_rows, input logic [CFG_W-1:0] n_cols);
		wait_idle();
		apb_write_reg(REG_ROWS, n_rows);
		apb_write_reg(REG_COLS, n_cols);
	endtask

	initial begin
		int random_items;
		int grid_no;
		int n;
		int width;
		int new_rows;
		int new_cols;
		bit abandoned;
		pattern_t pat;

		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		sample_valid = 1'b0;
		elevation = '0;
		result_stall = 1'b0;
		no_idle = 1'b0;
		sender_burst = 1'b0;
		hold_request = 0;
		hold_left = 0;
		run_left = 0;
		run_stall = 1'b0;
		idle_cycles = 0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// a few samples on the reset-time 64 x 64 grid, then abandoned by the writes
		send_grid(5, 64, PAT_WIDE);

		configure(7'd3, 7'd3);
		foreach (PEAK_GRID[i])
			send_sample(PEAK_GRID[i]);
		foreach (VALLEY_GRID[i])
			send_sample(VALLEY_GRID[i]);

		// zero acts as one: each sample is a whole grid
		configure(7'd0, 7'd0);
		send_sample(-16'sd32768);

		// above the maximum acts as 64
		configure(7'd127, 7'd1);
		send_grid(64, 1, PAT_WIDE);
		configure(7'd1, 7'd127);
		send_grid(64, 64, PAT_EXTREME);

		// restart in the middle of a grid
		configure(7'd5, 7'd5);
		send_grid(13, 5, PAT_TIES);
		wait_idle();
		apb_write_reg(REG_COLS, 7'd6);
		send_grid(30, 6, PAT_BUMPY);

		random_items = 0;
		grid_no = 0;
		abandoned = 1'b0;
		while (random_items < RANDOM_ITEMS) begin
			pat = pattern_t'($urandom_range(0, 3));
			no_idle = ($urandom_range(0, 4) == 0);
			if (grid_no == 0) begin
				// long result hold-off while samples keep coming back to back
				configure(7'd12, 7'd12);
				no_idle = 1'b0;
				sender_burst = 1'b1;
				hold_request = HOLD_CYCLES;
				send_grid(144, 12, PAT_BUMPY);
				sender_burst = 1'b0;
				n = 144;
				abandoned = 1'b0;
			end else begin
				if (abandoned || grid_no == 1 || $urandom_range(0, 2) != 0) begin
					if ($urandom_range(0, 11) == 0) begin
						new_rows = $urandom_range(13, 127);
						new_cols = $urandom_range(0, 4);
						if ($urandom_range(0, 1)) begin
							n = new_rows;
							new_rows = new_cols;
							new_cols = n;
						end
					end else begin
						new_rows = $urandom_range(0, 12);
						new_cols = $urandom_range(0, 12);
					end
					wait_idle();
					case ($urandom_range(0, 3))
						0: apb_write_reg(REG_ROWS, CFG_W'(new_rows));
						1: apb_write_reg(REG_COLS, CFG_W'(new_cols));
						default: begin
							apb_write_reg(REG_ROWS, CFG_W'(new_rows));
							apb_write_reg(REG_COLS, CFG_W'(new_cols));
						end
					endcase
				end
				width = tracker.eff_dim(tracker.cols_reg);
				n = tracker.eff_dim(tracker.rows_reg) * width;
				abandoned = 1'b0;
				if ($urandom_range(0, 9) == 0) begin
					n = $urandom_range(1, n);
					abandoned = 1'b1;
				end
				send_grid(n, width, pat);
			end
			random_items += n;
			grid_no++;
		end

		no_idle = 1'b0;
		wait_idle();
		repeat (10) @(posedge clk);
		if (tracker.error_count == 0 && tracker.awaited() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

// File: files.f
+incdir+hdl
hdl/glef_pkg.sv
hdl/glef_result_fifo.sv
hdl/grid_local_extremum_finder_unit.sv
tb/grid_local_extremum_finder_unit_tb.sv
